>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/arsl_pkg.sv
// Types, constants and helper functions of the address range symbol lookup.
package arsl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PADDR_W     = 4;

    localparam int MARK_NOSYM_BIT  = 0;
    localparam int MARK_WEAK_BIT   = 1;
    localparam int MARK_STATIC_BIT = 2;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REBASE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        REG_TABLE_BASE  = 2'd0,
        REG_TABLE_LIMIT = 2'd1,
        REG_LOAD_OFFSET = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        new_address;
        logic [15:0]        new_id;
        logic               new_nosym;
        logic               new_weak;
        logic               new_static;
        logic [31:0]        query_address;
        logic signed [31:0] rebase_delta;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [15:0] func_id;
        logic [31:0] func_start;
        logic [31:0] func_end;
        logic        is_static;
        logic        status;
    } out_t;

    typedef struct packed {
        logic [31:0]        table_base;
        logic [31:0]        table_limit;
        logic signed [31:0] load_offset;
    } cfg_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] ident;
        logic [2:0]  marks;
    } entry_t;

    // Smaller rank is preferred: entries with symbols, then weak, then global.
    function automatic logic [2:0] merge_rank(input logic [2:0] marks);
        merge_rank = {marks[MARK_NOSYM_BIT], ~marks[MARK_WEAK_BIT], marks[MARK_STATIC_BIT]};
    endfunction

endpackage

>>> design/arsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/arsl_cfg.sv
// APB register file holding the segment base, limit and load offset.
module arsl_cfg import arsl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                REG_TABLE_BASE:  cfg_next.table_base  = pwdata;
                REG_TABLE_LIMIT: cfg_next.table_limit = pwdata;
                REG_LOAD_OFFSET: cfg_next.load_offset = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TABLE_BASE:  prdata = cfg_reg.table_base;
            REG_TABLE_LIMIT: prdata = cfg_reg.table_limit;
            REG_LOAD_OFFSET: prdata = cfg_reg.load_offset;
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/address_range_symbol_lookup.sv
// Top level: sequencer, shared compare unit and sorted entry table.
// The table holds up to TABLE_DEPTH function entries sorted by start address in a single
// RAM with one write and one registered read port; every step of the sequencer does at
// most one table read and one write, and a single 32-bit compare drives the search.
// The search is a binary search of about log2(entries) probes. A lookup runs the probes
// after key set-up and a range check, then reads the matched and following entries. A
// rebase, a no-operation request or a lookup outside the segment skips the table. An
// insert merges into an equal stored entry; otherwise every stored entry above the
// insertion point is moved up one place and the new entry is written. A new transaction
// is taken only while the sequencer is idle; one finished result may wait in the output
// register meanwhile. No clearing pass is needed after reset.
`include "assert_macros.svh"

module address_range_symbol_lookup import arsl_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_PREP    = 13'b0000000000010,
        S_SRD     = 13'b0000000000100,
        S_SCMP    = 13'b0000000001000,
        S_INS_RD  = 13'b0000000010000,
        S_INS_CHK = 13'b0000000100000,
        S_INS_NEW = 13'b0000001000000,
        S_SHIFT   = 13'b0000010000000,
        S_PLACE   = 13'b0000100000000,
        S_LK_RD0  = 13'b0001000000000,
        S_LK_RD1  = 13'b0010000000000,
        S_LK_END  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    cfg_t cfg;

    arsl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t     state_reg, state_next;
    in_t        req_reg, req_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] rebase_reg, rebase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] sh_reg, sh_next;
    logic [IDX_W-1:0] wr_addr_reg, wr_addr_next;
    logic             wr_pend_reg, wr_pend_next;
    out_t       res_reg, res_next;
    out_t       m_data_reg, m_data_next;
    logic       m_valid_reg, m_valid_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    arsl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic       is_lookup;
    logic       probe_below;
    logic [CNT_W-1:0] cur_lo, cur_hi, cur_mid;
    logic [2:0] new_marks;
    logic [2:0] kept_marks;
    logic       take_new;

    assign is_lookup = (req_reg.req_type == REQ_LOOKUP);
    assign new_marks = {req_reg.new_static, req_reg.new_weak, req_reg.new_nosym};

    // Shared compare unit: is the probed entry below the key (or equal, for a lookup)?
    assign probe_below = (ram_rdata.addr < key_reg) || (is_lookup && ram_rdata.addr == key_reg);

    always_comb begin
        if (state_reg == S_SCMP) begin
            cur_lo = probe_below ? mid_reg + 1'b1 : lo_reg;
            cur_hi = probe_below ? hi_reg : mid_reg;
        end else begin
            cur_lo = lo_reg;
            cur_hi = hi_reg;
        end
        cur_mid = cur_lo + ((cur_hi - cur_lo) >> 1);
    end

    assign take_new   = merge_rank(new_marks) < merge_rank(ram_rdata.marks);
    assign kept_marks = take_new ? new_marks : ram_rdata.marks;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        key_next     = key_reg;
        rebase_next  = rebase_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        sh_next      = sh_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ram_we       = 1'b0;
        ram_waddr    = lo_reg[IDX_W-1:0];
        ram_wdata    = '0;
        ram_raddr    = '0;

        unique case (state_reg) inside
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    res_next = '0;
                    if (s_data.req_type == REQ_INSERT) begin
                        key_next = s_data.new_address + cfg.load_offset - rebase_reg;
                    end else begin
                        key_next = s_data.query_address - rebase_reg;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                lo_next = '0;
                hi_next = count_reg;
                unique case (req_reg.req_type)
                    REQ_INSERT: state_next = S_SRD;
                    REQ_LOOKUP: begin
                        if (key_reg < cfg.table_base || key_reg >= cfg.table_limit) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SRD;
                        end
                    end
                    REQ_REBASE: begin
                        rebase_next = rebase_reg + req_reg.rebase_delta;
                        state_next  = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SRD, S_SCMP: begin
                lo_next = cur_lo;
                hi_next = cur_hi;
                if (cur_lo < cur_hi) begin
                    mid_next   = cur_mid;
                    ram_raddr  = cur_mid[IDX_W-1:0];
                    state_next = S_SCMP;
                end else if (is_lookup) begin
                    state_next = (cur_lo == '0) ? S_DONE : S_LK_RD0;
                end else begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                ram_raddr  = lo_reg[IDX_W-1:0];
                state_next = (lo_reg < count_reg) ? S_INS_CHK : S_INS_NEW;
            end
            S_INS_CHK: begin
                if (ram_rdata.addr == key_reg) begin
                    // Equal address: merge into the stored entry.
                    ram_we          = 1'b1;
                    ram_wdata.addr  = key_reg;
                    ram_wdata.ident = take_new ? req_reg.new_id : ram_rdata.ident;
                    ram_wdata.marks = kept_marks;
                    ram_wdata.marks[MARK_STATIC_BIT] =
                        ram_rdata.marks[MARK_STATIC_BIT] && req_reg.new_static;
                    state_next = S_DONE;
                end else begin
                    state_next = S_INS_NEW;
                end
            end
            S_INS_NEW: begin
                if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                    res_next.status = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    sh_next      = count_reg;
                    wr_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Entries move up one place, each written in the cycle after it is read.
                if (wr_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_reg > lo_reg) begin
                    ram_raddr    = IDX_W'(sh_reg - 1'b1);
                    wr_addr_next = sh_reg[IDX_W-1:0];
                    wr_pend_next = 1'b1;
                    sh_next      = sh_reg - 1'b1;
                end else begin
                    wr_pend_next = 1'b0;
                    state_next   = S_PLACE;
                end
            end
            S_PLACE: begin
                ram_we          = 1'b1;
                ram_wdata.addr  = key_reg;
                ram_wdata.ident = req_reg.new_id;
                ram_wdata.marks = new_marks;
                count_next      = count_reg + 1'b1;
                state_next      = S_DONE;
            end
            S_LK_RD0: begin
                ram_raddr  = IDX_W'(lo_reg - 1'b1);
                state_next = S_LK_RD1;
            end
            S_LK_RD1: begin
                res_next.found      = 1'b1;
                res_next.func_id    = ram_rdata.ident;
                res_next.func_start = ram_rdata.addr + rebase_reg;
                res_next.is_static  = ram_rdata.marks[MARK_STATIC_BIT];
                if (lo_reg < count_reg) begin
                    ram_raddr  = lo_reg[IDX_W-1:0];
                    state_next = S_LK_END;
                end else begin
                    res_next.func_end = cfg.table_limit + rebase_reg;
                    state_next        = S_DONE;
                end
            end
            S_LK_END: begin
                res_next.func_end = ram_rdata.addr + rebase_reg;
                state_next        = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rebase_reg  <= '0;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rebase_reg  <= rebase_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        sh_reg      <= sh_next;
        wr_addr_reg <= wr_addr_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    `ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `ASSERT_IMPLIES(a_full_status, aclk, aresetn, m_valid && m_data.status,
                    count_reg == CNT_W'(TABLE_DEPTH) && !m_data.found)
    `ASSERT_IMPLIES(a_found_range, aclk, aresetn, m_valid && m_data.found,
                    m_data.func_start != m_data.func_end)
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

>>> tb/address_range_symbol_lookup_tb.sv
// Self-checking testbench for the address range symbol lookup, with its own table predictor.
module address_range_symbol_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arsl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_t                s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_t               m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    address_range_symbol_lookup dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    // Shadow of the symbol table, held in the unshifted address frame.
    logic [31:0] sym_addr  [TABLE_DEPTH];
    logic [15:0] sym_ident [TABLE_DEPTH];
    logic [2:0]  sym_marks [TABLE_DEPTH];
    int unsigned sym_count = 0;
    logic [31:0] slide     = '0;
    logic [31:0] reg_base  = '0;
    logic [31:0] reg_limit = '0;
    logic [31:0] reg_load  = '0;

    out_t        pending_answers[$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          calm        = 1'b0;
    logic [31:0] cluster     = '0;

    function automatic string answer_text(out_t a);
        return $sformatf("found=%0d id=%h start=%h end=%h static=%0d status=%0d",
                         a.found, a.func_id, a.func_start, a.func_end, a.is_static, a.status);
    endfunction

    task automatic note_failure(string text);
        fail_count++;
        if (fail_count <= 10) $display("%s", text);
    endtask

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Number of stored entries below a, or not above a when or_equal is set.
    function automatic int unsigned entries_below(logic [31:0] a, bit or_equal);
        int unsigned lo, hi, mid;
        lo = 0;
        hi = sym_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (sym_addr[mid] < a || (or_equal && sym_addr[mid] == a)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // An incoming entry wins if it has symbols, then if it is weak, then if it is global.
    function automatic bit displaces(logic [2:0] incoming, logic [2:0] stored);
        if (incoming[MARK_NOSYM_BIT] != stored[MARK_NOSYM_BIT])
            return !incoming[MARK_NOSYM_BIT];
        if (incoming[MARK_WEAK_BIT] != stored[MARK_WEAK_BIT])
            return incoming[MARK_WEAK_BIT];
        return stored[MARK_STATIC_BIT] && !incoming[MARK_STATIC_BIT];
    endfunction

    function automatic out_t resolve_request(in_t it);
        out_t        r;
        logic [31:0] a, q, stop;
        logic [2:0]  marks, kept;
        int unsigned pos, n, k;
        r = '0;
        case (it.req_type)
            REQ_INSERT: begin
                a = it.new_address + reg_load - slide;
                marks = {it.new_static, it.new_weak, it.new_nosym};
                pos = entries_below(a, 1'b0);
                if (pos < sym_count && sym_addr[pos] == a) begin
                    kept = sym_marks[pos];
                    if (displaces(marks, kept)) begin
                        sym_ident[pos] = it.new_id;
                        kept = marks;
                    end
                    kept[MARK_STATIC_BIT] = sym_marks[pos][MARK_STATIC_BIT]
                                          & marks[MARK_STATIC_BIT];
                    sym_marks[pos] = kept;
                end else if (sym_count >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    for (k = sym_count; k > pos; k--) begin
                        sym_addr[k]  = sym_addr[k-1];
                        sym_ident[k] = sym_ident[k-1];
                        sym_marks[k] = sym_marks[k-1];
                    end
                    sym_addr[pos]  = a;
                    sym_ident[pos] = it.new_id;
                    sym_marks[pos] = marks;
                    sym_count++;
                end
            end
            REQ_LOOKUP: begin
                q = it.query_address - slide;
                if (q >= reg_base && q < reg_limit) begin
                    n = entries_below(q, 1'b1);
                    if (n > 0) begin
                        stop = (n < sym_count) ? sym_addr[n] : reg_limit;
                        r.found      = 1'b1;
                        r.func_id    = sym_ident[n-1];
                        r.func_start = sym_addr[n-1] + slide;
                        r.func_end   = stop + slide;
                        r.is_static  = sym_marks[n-1][MARK_STATIC_BIT];
                    end
                end
            end
            REQ_REBASE: begin
                slide = slide + it.rebase_delta;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic in_t any_item();
        in_t it;
        it.req_type      = 2'($urandom_range(0, 3));
        it.new_address   = $urandom;
        it.new_id        = 16'($urandom);
        it.new_nosym     = 1'($urandom);
        it.new_weak      = 1'($urandom);
        it.new_static    = 1'($urandom);
        it.query_address = $urandom;
        it.rebase_delta  = $urandom;
        return it;
    endfunction

    // Builds an insert that lands on the given unshifted address.
    function automatic in_t insert_at(logic [31:0] target, logic [15:0] id, logic [2:0] marks);
        in_t it;
        it = any_item();
        it.req_type    = REQ_INSERT;
        it.new_address = target - reg_load + slide;
        it.new_id      = id;
        {it.new_static, it.new_weak, it.new_nosym} = marks;
        return it;
    endfunction

    function automatic in_t lookup_at(logic [31:0] target);
        in_t it;
        it = any_item();
        it.req_type      = REQ_LOOKUP;
        it.query_address = target + slide;
        return it;
    endfunction

    function automatic in_t simple_item(req_t kind);
        in_t it;
        it = any_item();
        it.req_type = kind;
        return it;
    endfunction

    function automatic logic [31:0] near_entry();
        logic [31:0] target;
        target = sym_addr[$urandom_range(0, sym_count - 1)];
        case ($urandom_range(0, 3))
            0: ;
            1: target = target + $urandom_range(1, 'hFF);
            2: target = target - 1;
            default: target = target + $urandom_range(1, 'hFFFF);
        endcase
        return target;
    endfunction

    function automatic in_t random_request();
        in_t         it;
        logic [31:0] target;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            case ($urandom_range(0, 2))
                0: target = (sym_count > 0) ? sym_addr[$urandom_range(0, sym_count - 1)]
                                            : $urandom;
                1: target = cluster + $urandom_range(0, 'hFFFF);
                default: target = $urandom;
            endcase
            it = insert_at(target, 16'($urandom), 3'($urandom));
        end else if (r < 85) begin
            if (sym_count > 0 && $urandom_range(0, 9) < 7) it = lookup_at(near_entry());
            else it = simple_item(REQ_LOOKUP);
        end else if (r < 93) begin
            it = simple_item(REQ_REBASE);
            if ($urandom_range(0, 1) == 1)
                it.rebase_delta = 32'($urandom_range(0, 'h1FFF)) - 32'h1000;
        end else begin
            it = simple_item(REQ_NONE);
        end
        return it;
    endfunction

    // Presents one transaction and records its predicted answer once it is taken.
    task automatic issue_request(in_t it);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) >= 45) gap = idle_span();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_answers.push_back(resolve_request(it));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        logic [31:0] seen;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // Straight into a read of the same register to confirm the write.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TABLE_BASE:  reg_base  = value;
            REG_TABLE_LIMIT: reg_limit = value;
            REG_LOAD_OFFSET: reg_load  = value;
            default: ;
        endcase
        if (seen !== value)
            note_failure($sformatf("register %s read back %h, written %h",
                                   idx.name(), seen, value));
    endtask

    task automatic configure(logic [31:0] base, logic [31:0] limit, logic [31:0] load);
        settle();
        write_reg(REG_TABLE_BASE, base);
        write_reg(REG_TABLE_LIMIT, limit);
        write_reg(REG_LOAD_OFFSET, load);
    endtask

    task automatic test_insert_and_lookup_edges();
        configure(32'h0, 32'hFFFF_FFFF, 32'h0);
        issue_request(lookup_at(32'h0));
        issue_request(simple_item(REQ_NONE));
        issue_request(insert_at(32'h0000_1000, 16'hFFFF, 3'b101));
        issue_request(insert_at(32'hFFFF_FFFF, 16'h0000, 3'b000));
        issue_request(insert_at(32'h0000_0000, 16'h1234, 3'b010));
        issue_request(lookup_at(32'h0000_0FFF));
        issue_request(lookup_at(32'h0000_1000));
        issue_request(lookup_at(32'hFFFF_FFFE));
        issue_request(lookup_at(32'hFFFF_FFFF));
    endtask

    task automatic test_merge_rules();
        // A weak global entry beats a static entry without symbols and clears the static mark.
        issue_request(insert_at(32'h0000_1000, 16'h0001, 3'b010));
        issue_request(insert_at(32'h0000_1000, 16'h0002, 3'b101));
        issue_request(insert_at(32'h0000_1000, 16'h0003, 3'b010));
        issue_request(lookup_at(32'h0000_1000));
        // Two static entries merge and stay static.
        issue_request(insert_at(32'h0000_2000, 16'h0005, 3'b110));
        issue_request(insert_at(32'h0000_2000, 16'h0006, 3'b101));
        issue_request(lookup_at(32'h0000_2800));
    endtask

    task automatic test_rebase_and_offsets();
        in_t it;
        it = simple_item(REQ_REBASE);
        it.rebase_delta = 32'h7FFF_FFFF;
        issue_request(it);
        it = simple_item(REQ_REBASE);
        it.rebase_delta = 32'h8000_0000;
        issue_request(it);
        it = simple_item(REQ_LOOKUP);
        it.query_address = 32'hFFFF_FFFF;
        issue_request(it);
        it.query_address = 32'h0000_0000;
        issue_request(it);
        configure(32'h0000_0800, 32'h0000_1800, 32'hFFFF_FFFF);
        it = simple_item(REQ_INSERT);
        it.new_address = 32'h0;
        issue_request(it);
        issue_request(lookup_at(32'h0000_07FF));
        issue_request(lookup_at(32'h0000_17FF));
        issue_request(lookup_at(32'h0000_1800));
        // A limit below the base leaves nothing in range.
        configure(32'h0000_3000, 32'h0000_1000, 32'h0);
        issue_request(lookup_at(32'h0000_2000));
    endtask

    task automatic test_random_traffic();
        int unsigned phase, count, i;
        cluster = $urandom;
        for (phase = 0; phase < 5; phase++) begin
            count = 100;
            calm  = 1'b0;
            case (phase)
                0: configure(32'h0, 32'hFFFF_FFFF, 32'h0);
                1: configure(cluster - 32'h8000, cluster + 32'h1_8000, $urandom);
                2: begin
                    configure(32'h0, 32'h0, 32'h8000_0000);
                    count = 50;
                end
                3: configure($urandom, $urandom, 32'h7FFF_FFFF);
                default: begin
                    configure(32'h0, 32'hFFFF_FFFF, $urandom);
                    calm = 1'b1;
                end
            endcase
            for (i = 0; i < count; i++) issue_request(random_request());
        end
        calm = 1'b0;
    endtask

    task automatic test_full_table();
        logic [31:0] next_addr, top;
        int unsigned i;
        configure(32'h0, 32'hFFFF_FFFF, $urandom);
        // Fill just below the highest entry so that each insert moves very few entries.
        calm = 1'b1;
        top = sym_addr[sym_count - 1];
        next_addr = (top >= 32'h1000) ? top - 32'h1000 : top + 1;
        while (sym_count < TABLE_DEPTH) begin
            issue_request(insert_at(next_addr, 16'($urandom), 3'($urandom)));
            next_addr++;
        end
        calm = 1'b0;
        for (i = 0; i < 6; i++)
            issue_request(insert_at($urandom, 16'($urandom), 3'($urandom)));
        for (i = 0; i < 6; i++)
            issue_request(insert_at(sym_addr[$urandom_range(0, TABLE_DEPTH - 1)],
                                    16'($urandom), 3'($urandom)));
        for (i = 0; i < 40; i++) issue_request(random_request());
    endtask

    // Result side: random back-pressure, with no new stalls started while the stimulus runs calm.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 15) begin
            m_ready    <= 1'b0;
            stall_left <= idle_span() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", answer_text(m_data)));
            end else begin
                want = pending_answers.pop_front();
                if (m_data !== want) begin
                    note_failure($sformatf("mismatch: expected %s", answer_text(want)));
                    if (fail_count <= 10) $display("          actual   %s", answer_text(m_data));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_insert_and_lookup_edges();
        test_merge_rules();
        test_rebase_and_offsets();
        test_random_traffic();
        test_full_table();
        settle();
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/arsl_pkg.sv
design/arsl_ram.sv
design/arsl_cfg.sv
design/address_range_symbol_lookup.sv
tb/address_range_symbol_lookup_tb.sv
